// ===== hw/rtl/mlpf_pkg.sv =====
`default_nettype none

package mlpf_pkg;

   localparam int NUM_LEVELS = 8;
   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;

   localparam int LEVEL_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_BAD_LEVEL = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   // one stored item of the sorted row
   typedef struct packed {
      logic                  valid;
      logic [LEVEL_W-1:0]    level;
      logic [DATA_WIDTH-1:0] value;
   } entry_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic                  push;
      logic                  pop;
      logic [LEVEL_W-1:0]    level;
      logic [DATA_WIDTH-1:0] value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mlpf_cell.sv =====
`default_nettype none

module mlpf_cell
   import mlpf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire entry_type     prev_entry,
   input  wire logic          prev_after,
   input  wire entry_type     next_entry,
   output entry_type          entry,
   output logic               after
);

   logic                  valid_ff;
   logic                  valid_in;
   logic [LEVEL_W-1:0]    level_ff;
   logic [LEVEL_W-1:0]    level_in;
   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;

   // new item belongs before this entry (equal levels keep arrival order)
   assign after = !valid_ff || (level_ff > ctrl.level);

   assign entry.valid = valid_ff;
   assign entry.level = level_ff;
   assign entry.value = value_ff;

   always_comb begin
      valid_in = valid_ff;
      level_in = level_ff;
      value_in = value_ff;
      if (ctrl.pop) begin
         valid_in = next_entry.valid;
         level_in = next_entry.level;
         value_in = next_entry.value;
      end else if (ctrl.push && after) begin
         if (prev_after) begin
            valid_in = prev_entry.valid;
            level_in = prev_entry.level;
            value_in = prev_entry.value;
         end else begin
            valid_in = 1'b1;
            level_in = ctrl.level;
            value_in = ctrl.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/multi_level_priority_fifo.sv =====
`default_nettype none

// channel  direction  handshake             contents
// req      in         req_tvalid/req_tready op (tuser), level, push_value
// rsp      out        rsp_tvalid/rsp_tready pop_value, pop_level, status, now_empty
//
// one transaction per cycle while rsp is not stalled: the row of CAPACITY cells,
// kept sorted by level, inserts a push or shifts out a pop as each is accepted
// a new request can be taken in the same cycle that the previous result leaves
// reset empties every cell and drops any pending result
// a stalled rsp holds its result and blocks req until taken

module multi_level_priority_fifo
   import mlpf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // level[3:0], push_value[31:0], zero pad
   input  wire logic [0:0]  req_tuser,   // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // pop_value[31:0], pop_level[3:0], status[1:0],
                                         // now_empty, zero pad
);

   logic        req_op;
   logic [3:0]  req_level;
   logic [31:0] req_push_value;

   assign req_op         = req_tuser[0];
   assign req_level      = req_tdata[3:0];
   assign req_push_value = req_tdata[35:4];

   logic          accept;
   logic          level_ok;
   logic          full;
   logic          empty;
   logic          push_go;
   logic          pop_go;
   cell_ctrl_type ctrl;
   entry_type     cells  [CAPACITY];
   logic          after  [CAPACITY];

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] pop_value_ff;
   logic [31:0] pop_value_in;
   logic [3:0]  pop_level_ff;
   logic [3:0]  pop_level_in;
   status_type  status_ff;
   status_type  status_in;
   logic        now_empty_ff;
   logic        now_empty_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign level_ok = ({28'd0, req_level} < 32'(NUM_LEVELS));
   assign full     = cells[CAPACITY-1].valid;
   assign empty    = !cells[0].valid;
   assign push_go  = accept && (req_op == OP_PUSH) && level_ok && !full;
   assign pop_go   = accept && (req_op == OP_POP) && !empty;

   assign ctrl.push  = push_go;
   assign ctrl.pop   = pop_go;
   assign ctrl.level = LEVEL_W'(req_level);
   assign ctrl.value = DATA_WIDTH'(req_push_value);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type prev_entry;
      entry_type next_entry;
      logic      prev_after;

      if (i == 0) begin : g_first
         assign prev_entry = '0;
         assign prev_after = 1'b0;
      end else begin : g_mid
         assign prev_entry = cells[i-1];
         assign prev_after = after[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_entry = '0;
      end else begin : g_inner
         assign next_entry = cells[i+1];
      end

      mlpf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_entry (prev_entry),
         .prev_after (prev_after),
         .next_entry (next_entry),
         .entry      (cells[i]),
         .after      (after[i])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pop_value_in = pop_value_ff;
      pop_level_in = pop_level_ff;
      status_in    = status_ff;
      now_empty_in = now_empty_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         pop_value_in = '0;
         pop_level_in = '0;
         status_in    = STATUS_OK;
         now_empty_in = empty;
         if (req_op == OP_POP) begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               pop_value_in = 32'(cells[0].value);
               pop_level_in = 4'(cells[0].level);
               now_empty_in = !cells[1].valid;
            end
         end else if (!level_ok) begin
            status_in = STATUS_BAD_LEVEL;
         end else if (full) begin
            status_in = STATUS_FULL;
         end else begin
            now_empty_in = 1'b0;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_value_ff <= pop_value_in;
      pop_level_ff <= pop_level_in;
      status_ff    <= status_in;
      now_empty_ff <= now_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, now_empty_ff, status_ff, pop_level_ff, pop_value_ff};

endmodule

`default_nettype wire
